// File: hw/rtl/weod_pkg.sv
package weod_pkg;

  localparam int ENERGY_W   = 47;
  localparam int POS_W      = 32;
  localparam int WLEN_W     = 16;
  localparam int CC_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 47;

  localparam int MAX_CHANNELS_DEF = 2;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 2'd2;

  localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RST    = 16'd4410;
  localparam logic [ENERGY_W-1:0] ENERGY_THRESHOLD_RST = 47'd64424509440;
  localparam logic [CC_W-1:0]     CHANNEL_COUNT_RST    = 2'd2;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // One frame's window state on its way from the window accumulator to the detector.
  typedef struct packed {
    logic                clr;
    logic                done;
    logic [ENERGY_W-1:0] energy;
    logic [POS_W-1:0]    pos;
  } weod_win_t;

  typedef struct packed {
    logic v2;
    logic v3;
  } weod_occ_t;

endpackage

// File: hw/rtl/weod_lane.sv
module weod_lane #(
  parameter int SAMPLE_BITS = weod_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load_i,
  input  logic                         act_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic [2*SAMPLE_BITS-1:0]     sq_o
);

  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic [2*SAMPLE_BITS-1:0]        sq_r;
  logic [2*SAMPLE_BITS-1:0]        sq_nxt;

  // The square of the most negative code is still positive at twice the width.
  assign prod   = (2*SAMPLE_BITS)'(sample_i) * (2*SAMPLE_BITS)'(sample_i);
  assign sq_nxt = act_i ? unsigned'(prod) : '0;

  always_ff @(posedge clk) begin
    if (load_i) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule

// File: hw/rtl/weod_window.sv
module weod_window #(
  parameter int LANES       = weod_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS = weod_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [2*SAMPLE_BITS-1:0]      sq_i [LANES],
  input  logic                          v1_i,
  input  logic                          last1_i,
  input  logic                          ld2_i,
  input  logic                          ld3_i,
  input  logic [weod_pkg::WLEN_W-1:0]   window_length_i,
  output weod_pkg::weod_occ_t           occ_o,
  output weod_pkg::weod_win_t           win_o
);

  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = SQ_W + $clog2(LANES + 1);
  localparam int EW     = weod_pkg::ENERGY_W;
  localparam int ACC_W  = (SUM_W > EW ? SUM_W : EW) + 1;
  localparam int WL_W   = weod_pkg::WLEN_W;
  localparam int PW     = weod_pkg::POS_W;

  logic                v2_r;
  logic                last2_r;
  logic [SUM_W-1:0]    fe2_r;
  logic [SUM_W-1:0]    fe_nxt;

  logic                v3_r;
  weod_pkg::weod_win_t win_r;
  weod_pkg::weod_win_t win_nxt;

  logic [EW-1:0]       sum_r;
  logic [EW-1:0]       sum_nxt;
  logic [WL_W-1:0]     frames_r;
  logic [WL_W-1:0]     frames_nxt;
  logic [PW-1:0]       pos_r;
  logic [PW-1:0]       pos_nxt;

  logic [WL_W-1:0]     len;
  logic [WL_W:0]       count;
  logic                done;
  logic [ACC_W-1:0]    acc;
  logic [EW-1:0]       energy;
  logic                move;

  // Merge the lane squares of one frame.
  always_comb begin
    fe_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      fe_nxt = fe_nxt + SUM_W'(sq_i[i]);
    end
  end

  assign len    = (window_length_i == '0) ? WL_W'(1) : window_length_i;
  assign count  = {1'b0, frames_r} + (WL_W + 1)'(1);
  assign done   = count >= {1'b0, len};
  assign acc    = ACC_W'(sum_r) + ACC_W'(fe2_r);
  assign energy = (acc > ACC_W'(weod_pkg::ENERGY_MAX)) ? weod_pkg::ENERGY_MAX : acc[EW-1:0];
  assign move   = v2_r && ld3_i;

  always_comb begin
    sum_nxt        = sum_r;
    frames_nxt     = frames_r;
    pos_nxt        = pos_r;
    win_nxt.clr    = 1'b0;
    win_nxt.done   = 1'b0;
    win_nxt.energy = energy;
    win_nxt.pos    = pos_r;
    if (last2_r) begin
      // The frame marked last drops its window and restarts the stream.
      sum_nxt     = '0;
      frames_nxt  = '0;
      pos_nxt     = '0;
      win_nxt.clr = 1'b1;
    end else if (done) begin
      sum_nxt      = '0;
      frames_nxt   = '0;
      pos_nxt      = pos_r + PW'(count);
      win_nxt.done = 1'b1;
    end else begin
      sum_nxt    = energy;
      frames_nxt = count[WL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      sum_r    <= '0;
      frames_r <= '0;
      pos_r    <= '0;
    end else begin
      if (ld2_i) begin
        v2_r <= v1_i;
      end
      if (ld3_i) begin
        v3_r <= v2_r;
      end
      if (move) begin
        sum_r    <= sum_nxt;
        frames_r <= frames_nxt;
        pos_r    <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2_i && v1_i) begin
      fe2_r   <= fe_nxt;
      last2_r <= last1_i;
    end
    if (move) begin
      win_r <= win_nxt;
    end
  end

  assign occ_o.v2 = v2_r;
  assign occ_o.v3 = v3_r;
  assign win_o    = win_r;

endmodule

// File: hw/rtl/weod_detect.sv
module weod_detect (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          v3_i,
  input  weod_pkg::weod_win_t           win_i,
  input  logic [weod_pkg::ENERGY_W-1:0] energy_threshold_i,
  input  logic                          out_stall_i,
  output logic                          en_out_o,
  output logic                          out_valid_o,
  output logic [weod_pkg::POS_W-1:0]    onset_position_o,
  output logic [weod_pkg::ENERGY_W-1:0] onset_energy_o
);

  localparam int EW = weod_pkg::ENERGY_W;

  logic [EW-1:0]             prev_r;
  logic                      has_prev_r;
  logic                      out_valid_r;
  logic [weod_pkg::POS_W-1:0] pos_r;
  logic [EW-1:0]             energy_r;

  logic [EW:0]               diff;
  logic                      rise;
  logic                      fire;
  logic                      take;

  // A negative difference shows in the top bit; otherwise it must beat the threshold.
  assign diff     = {1'b0, win_i.energy} - {1'b0, prev_r};
  assign rise     = !diff[EW] && (diff[EW-1:0] > energy_threshold_i);
  assign en_out_o = !out_valid_r || !out_stall_i;
  assign take     = v3_i && en_out_o;
  assign fire     = take && !win_i.clr && win_i.done && has_prev_r && rise;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      has_prev_r  <= 1'b0;
    end else begin
      if (en_out_o) begin
        out_valid_r <= fire;
      end
      if (take) begin
        if (win_i.clr) begin
          prev_r     <= '0;
          has_prev_r <= 1'b0;
        end else if (win_i.done) begin
          prev_r     <= win_i.energy;
          has_prev_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos_r    <= win_i.pos;
      energy_r <= win_i.energy;
    end
  end

  assign out_valid_o      = out_valid_r;
  assign onset_position_o = pos_r;
  assign onset_energy_o   = energy_r;

endmodule

// File: hw/rtl/windowed_energy_onset_detector.sv
// A result passes the lane, merged frame, window and output registers in that order.
// Throughput: one item per cycle unless stalled; the accumulator adds one frame per cycle.
// Lanes square the channel samples, a merge stage sums them, the detector compares windows.
// The output register stalls; at most three more items are taken before the input stalls.
// Reset is synchronous and active low: it clears the window state, the previous window
// and the output, and returns the configuration registers to their reset values.
module windowed_energy_onset_detector #(
  parameter int MAX_CHANNELS = weod_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = weod_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]   in_right_sample,
  input  logic                            in_last_frame,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [weod_pkg::POS_W-1:0]      out_onset_position,
  output logic [weod_pkg::ENERGY_W-1:0]   out_onset_energy,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [weod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [weod_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Only two sample fields exist, so no more than two lanes are ever built.
  localparam int LANES = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;

  logic [weod_pkg::WLEN_W-1:0]   window_length_r;
  logic [weod_pkg::ENERGY_W-1:0] energy_threshold_r;
  logic [weod_pkg::CC_W-1:0]     channel_count_r;

  logic                     v1_r;
  logic                     last1_r;
  logic                     ld1;
  logic                     ld2;
  logic                     ld3;
  logic                     en_out;
  logic                     accept;
  logic [2*SAMPLE_BITS-1:0] sq [LANES];
  weod_pkg::weod_occ_t      occ;
  weod_pkg::weod_win_t      win;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r    <= weod_pkg::WINDOW_LENGTH_RST;
      energy_threshold_r <= weod_pkg::ENERGY_THRESHOLD_RST;
      channel_count_r    <= weod_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        weod_pkg::REG_WINDOW_LENGTH:    window_length_r    <= cfg_data[weod_pkg::WLEN_W-1:0];
        weod_pkg::REG_ENERGY_THRESHOLD: energy_threshold_r <= cfg_data[weod_pkg::ENERGY_W-1:0];
        weod_pkg::REG_CHANNEL_COUNT:    channel_count_r    <= cfg_data[weod_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage takes a new item when it is empty or its item moves on.
  assign ld3      = !occ.v3 || en_out;
  assign ld2      = !occ.v2 || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1;
  assign accept   = in_valid && ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last1_r <= in_last_frame;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    weod_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk     (clk),
      .load_i  (accept),
      .act_i   (channel_count_r > weod_pkg::CC_W'(i)),
      .sample_i(i == 0 ? in_left_sample : in_right_sample),
      .sq_o    (sq[i])
    );
  end

  weod_window #(
    .LANES      (LANES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .sq_i           (sq),
    .v1_i           (v1_r),
    .last1_i        (last1_r),
    .ld2_i          (ld2),
    .ld3_i          (ld3),
    .window_length_i(window_length_r),
    .occ_o          (occ),
    .win_o          (win)
  );

  weod_detect u_detect (
    .clk               (clk),
    .rst_n             (rst_n),
    .v3_i              (occ.v3),
    .win_i             (win),
    .energy_threshold_i(energy_threshold_r),
    .out_stall_i       (out_stall),
    .en_out_o          (en_out),
    .out_valid_o       (out_valid),
    .onset_position_o  (out_onset_position),
    .onset_energy_o    (out_onset_energy)
  );

endmodule

// File: hw/rtl/weod_check.sv
module weod_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [weod_pkg::POS_W-1:0]    out_onset_position,
  input logic [weod_pkg::ENERGY_W-1:0] out_onset_energy
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_onset_position) && $stable(out_onset_energy))
    else $error("stalled result item changed");

  // The input only backs up behind a result that is held at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

  // An onset window rose above the one before, so its energy cannot be zero.
  a_energy_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_onset_energy != '0)
    else $error("onset reported with zero energy");

endmodule

bind windowed_energy_onset_detector weod_check u_weod_check (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_onset_position(out_onset_position),
  .out_onset_energy  (out_onset_energy)
);
